[rtl/lcap_pkg.sv]
// Shared types, constants and helpers for the linear cellular automaton generator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package lcap_pkg;

    // Geometry of the automaton.
    localparam int CELLS      = 64;
    localparam int MAX_RADIUS = 3;
    localparam int NBR_W      = 2 * MAX_RADIUS + 1;

    // Fixed field widths.
    localparam int DATA_W    = 64;
    localparam int LEN_W     = 7;
    localparam int SIDE_MASKS = 3;
    localparam int MASK_REGS = 2 * SIDE_MASKS + 1;
    localparam logic [LEN_W-1:0] OUT_LEN_RESET = LEN_W'(32);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_MASK_SELF   = 3'd0,
        REG_MASK_RIGHT1 = 3'd1,
        REG_MASK_RIGHT2 = 3'd2,
        REG_MASK_RIGHT3 = 3'd3,
        REG_MASK_LEFT1  = 3'd4,
        REG_MASK_LEFT2  = 3'd5,
        REG_MASK_LEFT3  = 3'd6,
        REG_OUT_LEN     = 3'd7
    } reg_idx_t;

    // Per-beat control handed to every cell.
    typedef struct packed {
        logic en;    // a beat was accepted this cycle
        logic load;  // the beat is a seed load, not a step
    } cell_ctl_t;

    typedef logic [MASK_REGS-1:0][DATA_W-1:0] mask_bank_t;

    // Register that holds the coupling for neighbor offset d.
    function automatic reg_idx_t offset_reg(input int d);
        reg_idx_t r;
        if (d == 0) begin
            r = REG_MASK_SELF;
        end
        else if (d > 0) begin
            r = reg_idx_t'(3'(d));
        end
        else begin
            r = reg_idx_t'(3'(SIDE_MASKS - d));
        end
        return r;
    endfunction

    // Bits of a 64-bit word that carry cells (cell 0 at the MSB).
    function automatic logic [DATA_W-1:0] row_mask();
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < CELLS; i++) begin
            m[DATA_W-1-i] = 1'b1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/lcap_cell.sv]
// One automaton cell: a single state bit and its masked XOR update.
// Depends on lcap_pkg.
`default_nettype none

module lcap_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lcap_pkg::cell_ctl_t     ctl,
    input  wire logic                    seed_bit,
    input  wire logic [lcap_pkg::NBR_W-1:0] nbr,
    input  wire logic [lcap_pkg::NBR_W-1:0] tap,
    output logic                         next_bit,
    output logic                         cell_bit
);
    import lcap_pkg::*;

    logic cell_reg;
    logic cell_next;

    // Load the seed, or fold the coupled neighbors together.
    always_comb
    begin
        if (ctl.load) begin
            cell_next = seed_bit;
        end
        else begin
            cell_next = ^(nbr & tap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cell_reg <= 1'b0;
        end
        else if (ctl.en) begin
            cell_reg <= cell_next;
        end
    end

    assign next_bit = cell_next;
    assign cell_bit = cell_reg;

endmodule

`default_nettype wire

[rtl/lcap_cfg.sv]
// Configuration registers: the seven coupling masks and the output length.
// Depends on lcap_pkg.
`default_nettype none

module lcap_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire lcap_pkg::reg_idx_t            cfg_index,
    input  wire logic [lcap_pkg::DATA_W-1:0]   cfg_data,
    output lcap_pkg::mask_bank_t               masks,
    output logic [lcap_pkg::LEN_W-1:0]         out_len
);
    import lcap_pkg::*;

    mask_bank_t         mask_reg;
    logic [LEN_W-1:0]   out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg    <= '0;
            out_len_reg <= OUT_LEN_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_index) inside
                REG_MASK_SELF, REG_MASK_RIGHT1, REG_MASK_RIGHT2, REG_MASK_RIGHT3,
                REG_MASK_LEFT1, REG_MASK_LEFT2, REG_MASK_LEFT3:
                    mask_reg[cfg_index] <= cfg_data;
                REG_OUT_LEN:
                    out_len_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign masks   = mask_reg;
    assign out_len = out_len_reg;

endmodule

`default_nettype wire

[rtl/linear_cellular_automaton_prng_top.sv]
// Top level of the banded linear cellular automaton generator.
// Depends on lcap_pkg, lcap_cfg and lcap_cell.
`default_nettype none
//
//  channel | handshake            | payload                 | beat means
//  --------+----------------------+-------------------------+---------------------------
//  in      | in_valid / in_stall  | kind, seed_value        | step the row or load seed
//  out     | out_valid / out_stall| output_bits             | leading cells after a beat
//  cfg     | cfg_we               | cfg_index, cfg_data     | write one register
//
//  Timing: the row of cells updates at the accepting edge and the result lands in
//  the output register on that same edge, so a new beat can be taken on every
//  clock while in_stall is low.
//  The output register parts the two sides: in_stall rises only while a result is
//  held and the consumer stalls.
//  Reset: cells cleared, masks cleared, output length 32, no result pending.
//
module linear_cellular_automaton_prng_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          kind,
    input  wire logic [lcap_pkg::DATA_W-1:0]   seed_value,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [lcap_pkg::DATA_W-1:0]        output_bits,
    // configuration
    input  wire logic                          cfg_we,
    input  wire lcap_pkg::reg_idx_t            cfg_index,
    input  wire logic [lcap_pkg::DATA_W-1:0]   cfg_data
);
    import lcap_pkg::*;

    localparam logic [DATA_W-1:0] ROW_MASK = row_mask();

    mask_bank_t         masks;
    logic [LEN_W-1:0]   out_len;

    logic               in_acc;
    cell_ctl_t          ctl;
    logic [CELLS-1:0]   cell_q;
    logic [CELLS-1:0]   next_q;
    logic [DATA_W-1:0]  row_next;
    logic [DATA_W-1:0]  lead_mask;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  out_bits_reg;

    lcap_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .masks     (masks),
        .out_len   (out_len)
    );

    // Hold the input only while a finished result waits on a stalled consumer.
    assign in_stall = out_valid_reg & out_stall;
    assign in_acc   = in_valid & ~in_stall;
    assign ctl.en   = in_acc;
    assign ctl.load = kind;

    // The row: cell i sits at bit DATA_W-1-i of every word; neighbors off
    // the ends of the row read as zero.
    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        logic [NBR_W-1:0] nbr;
        logic [NBR_W-1:0] tap;

        for (genvar k = 0; k < NBR_W; k++) begin : g_tap
            localparam int D = k - MAX_RADIUS;
            if ((i + D >= 0) && (i + D < CELLS)) begin : g_in
                assign nbr[k] = cell_q[i + D];
            end
            else begin : g_edge
                assign nbr[k] = 1'b0;
            end
            assign tap[k] = masks[offset_reg(D)][DATA_W-1-i];
        end

        lcap_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .seed_bit (seed_value[DATA_W-1-i]),
            .nbr      (nbr),
            .tap      (tap),
            .next_bit (next_q[i]),
            .cell_bit (cell_q[i])
        );
    end

    // Gather the new row into word order and keep only the leading cells.
    always_comb
    begin
        row_next  = '0;
        lead_mask = '0;
        for (int i = 0; i < CELLS; i++) begin
            row_next[DATA_W-1-i] = next_q[i];
        end
        for (int i = 0; i < DATA_W; i++) begin
            lead_mask[DATA_W-1-i] = (LEN_W'(i) < out_len);
        end
    end

    // Advance the output register on every accepted beat; drop valid once taken.
    always_comb
    begin
        if (in_acc) begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            out_bits_reg <= row_next & lead_mask;
        end
    end

    assign out_valid   = out_valid_reg;
    assign output_bits = out_bits_reg;

    // A seed beat shows up as the masked seed on the next cycle.
    a_seed_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind) |=> (output_bits == $past(seed_value & ROW_MASK & lead_mask)))
        else $error("seed beat did not produce the loaded row");

    // The row moves only on an accepted beat.
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(cell_q))
        else $error("cells changed without an accepted beat");

    // Every accepted beat leaves a result pending.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid)
        else $error("accepted beat produced no result");

    // A result never shows cells past the output length.
    a_row_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> ((output_bits & ~$past(lead_mask)) == '0))
        else $error("result has bits beyond the output length");

endmodule

`default_nettype wire
